[design/sfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

  localparam int FREQ_W = 24;
  localparam int PERIOD_W = 16;
  localparam int CODE_W = 4;
  localparam int CFG_ADDR_W = 1;

  localparam longint unsigned CLOCK_HZ = 64'd16000000;
  localparam int FRACTION_BITS = 8;

  // Largest prescaler is /1024, so the divisor grows by up to ten bits.
  localparam int MAX_SHIFT = 10;
  localparam int DEN_W = FREQ_W + MAX_SHIFT;
  // One quotient bit beyond the period width flags q - 1 above the period range.
  localparam int QUO_W = PERIOD_W + 1;
  localparam int NUM_W = 40;

  localparam logic [NUM_W-1:0] NUMERATOR = NUM_W'(CLOCK_HZ) << FRACTION_BITS;
  localparam logic [NUM_W-1:0] NUM_HIGH = NUMERATOR >> QUO_W;
  localparam logic [DEN_W-1:0] REM_INIT = DEN_W'(NUM_HIGH);

  localparam logic [FREQ_W-1:0] THR_DIV1 = FREQ_W'(245) << FRACTION_BITS;
  localparam logic [FREQ_W-1:0] THR_DIV8 = FREQ_W'(31) << FRACTION_BITS;
  localparam logic [FREQ_W-1:0] THR_DIV64 = FREQ_W'(4) << FRACTION_BITS;
  localparam logic [FREQ_W-1:0] THR_DIV256 = FREQ_W'(1) << FRACTION_BITS;

  localparam logic [FREQ_W-1:0] MIN_FREQ_RST = 24'd1024;
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST = 24'd7680000;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_FREQ = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_FREQ = 1'd1;

  typedef logic [CODE_W-1:0] clksel_t;
  localparam clksel_t CS_DIV1 = 4'd9;
  localparam clksel_t CS_DIV8 = 4'd10;
  localparam clksel_t CS_DIV64 = 4'd11;
  localparam clksel_t CS_DIV256 = 4'd12;
  localparam clksel_t CS_DIV1024 = 4'd13;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             ovf;
    clksel_t          code;
  } div_t;

endpackage

`default_nettype wire

[design/sfp_clamp.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfp_clamp (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [sfp_pkg::FREQ_W-1:0]     min_freq,
  input  wire  [sfp_pkg::FREQ_W-1:0]     max_freq,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [sfp_pkg::FREQ_W-1:0]     in_freq,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [sfp_pkg::FREQ_W-1:0]     out_freq
);

  logic                         valid_r;
  logic [sfp_pkg::FREQ_W-1:0]   freq_r;
  logic [sfp_pkg::FREQ_W-1:0]   lo;
  logic [sfp_pkg::FREQ_W-1:0]   freq_nxt;

  // Apply the minimum first, then the maximum.
  always_comb begin
    lo = (in_freq < min_freq) ? min_freq : in_freq;
    freq_nxt = (lo > max_freq) ? max_freq : lo;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      freq_r <= freq_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_freq = freq_r;

endmodule

`default_nettype wire

[design/sfp_prescale.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfp_prescale (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [sfp_pkg::FREQ_W-1:0]     in_freq,
  output logic                           out_valid,
  input  wire                            out_ready,
  output sfp_pkg::div_t                  out_data
);

  logic                 valid_r;
  sfp_pkg::div_t        data_r;
  sfp_pkg::div_t        data_nxt;
  sfp_pkg::clksel_t     code;
  logic [3:0]           shift;
  logic [sfp_pkg::DEN_W-1:0] den;

  // Pick the prescaler from the clamped frequency.
  always_comb begin
    if (in_freq >= sfp_pkg::THR_DIV1) begin
      code = sfp_pkg::CS_DIV1;
      shift = 4'd0;
    end else if (in_freq >= sfp_pkg::THR_DIV8) begin
      code = sfp_pkg::CS_DIV8;
      shift = 4'd3;
    end else if (in_freq >= sfp_pkg::THR_DIV64) begin
      code = sfp_pkg::CS_DIV64;
      shift = 4'd6;
    end else if (in_freq >= sfp_pkg::THR_DIV256) begin
      code = sfp_pkg::CS_DIV256;
      shift = 4'd8;
    end else begin
      code = sfp_pkg::CS_DIV1024;
      shift = 4'd10;
    end
    den = sfp_pkg::DEN_W'(in_freq) << shift;
    data_nxt.rem = sfp_pkg::REM_INIT;
    data_nxt.den = den;
    data_nxt.quo = '0;
    // Quotient would need more bits than kept: saturate. Also covers zero.
    data_nxt.ovf = (sfp_pkg::NUM_HIGH >= sfp_pkg::NUM_W'(den));
    data_nxt.code = code;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data = data_r;

endmodule

`default_nettype wire

[design/sfp_div_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfp_div_stage (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                num_bit,
  input  wire                in_valid,
  output logic               in_ready,
  input  sfp_pkg::div_t      in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output sfp_pkg::div_t      out_data
);

  logic                        valid_r;
  sfp_pkg::div_t               data_r;
  sfp_pkg::div_t               data_nxt;
  logic [sfp_pkg::DEN_W:0]     trial;
  logic [sfp_pkg::DEN_W:0]     diff;
  logic                        ge;

  // One restoring step: bring down the next numerator bit, subtract if it fits.
  always_comb begin
    trial = {in_data.rem, num_bit};
    diff = trial - {1'b0, in_data.den};
    ge = (trial >= {1'b0, in_data.den});
    data_nxt = in_data;
    data_nxt.rem = ge ? diff[sfp_pkg::DEN_W-1:0] : trial[sfp_pkg::DEN_W-1:0];
    data_nxt.quo = {in_data.quo[sfp_pkg::QUO_W-2:0], ge};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data = data_r;

endmodule

`default_nettype wire

[design/sfp_sat.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfp_sat (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  sfp_pkg::div_t                    in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [sfp_pkg::PERIOD_W-1:0]     out_period,
  output sfp_pkg::clksel_t                 out_code
);

  logic                           valid_r;
  logic [sfp_pkg::PERIOD_W-1:0]   period_r;
  sfp_pkg::clksel_t               code_r;
  logic [sfp_pkg::PERIOD_W-1:0]   period_nxt;
  logic [sfp_pkg::QUO_W-1:0]      q_m1;

  // Drop one from the quotient; clip at zero and at the period range.
  always_comb begin
    q_m1 = in_data.quo - sfp_pkg::QUO_W'(1);
    if (in_data.ovf || (in_data.quo[sfp_pkg::QUO_W-1] &&
        (in_data.quo[sfp_pkg::QUO_W-2:0] != '0))) begin
      period_nxt = sfp_pkg::PERIOD_MAX;
    end else if (in_data.quo == '0) begin
      period_nxt = '0;
    end else begin
      period_nxt = q_m1[sfp_pkg::PERIOD_W-1:0];
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      period_r <= period_nxt;
      code_r <= in_data.code;
    end
  end

  assign out_valid = valid_r;
  assign out_period = period_r;
  assign out_code = code_r;

endmodule

`default_nettype wire

[design/step_frequency_to_timer_period.sv]
// Pipeline from input transaction to result: clamp, prescaler select,
//   17 restoring divider steps, saturation, one register stage each.
// Throughput: one transaction per cycle absent back-pressure; each stage holds
//   its own valid bit and fills a bubble ahead of it while the output stalls.
// Reset (rst_n low, synchronous): all valid bits clear, min_freq returns to
//   1024 (4 Hz) and max_freq to 7680000 (30000 Hz).
`timescale 1ns / 1ps
`default_nettype none

module step_frequency_to_timer_period (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Configuration write port
  input  wire                                  cfg_we,
  input  wire  [sfp_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire  [sfp_pkg::FREQ_W-1:0]           cfg_wdata,
  // Request stream
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [23:0]                          in_tdata,   // [23:0] freq_q8
  // Result stream
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [23:0]                          out_tdata   // [15:0] period_ticks,
                                                           // [19:16] clock_select,
                                                           // [23:20] zero
);

  localparam int NSTEP = sfp_pkg::QUO_W;

  // Frequency range registers; writes land at once, no handshake.
  logic [sfp_pkg::FREQ_W-1:0] min_freq_r;
  logic [sfp_pkg::FREQ_W-1:0] max_freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_freq_r <= sfp_pkg::MIN_FREQ_RST;
      max_freq_r <= sfp_pkg::MAX_FREQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sfp_pkg::REG_MIN_FREQ: min_freq_r <= cfg_wdata;
        sfp_pkg::REG_MAX_FREQ: max_freq_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1: clamp the requested frequency to the configured range.
  logic                        clamp_valid;
  logic                        clamp_ready;
  logic [sfp_pkg::FREQ_W-1:0]  clamp_freq;

  sfp_clamp u_clamp (
    .clk       (clk),
    .rst_n     (rst_n),
    .min_freq  (min_freq_r),
    .max_freq  (max_freq_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_freq   (in_tdata[sfp_pkg::FREQ_W-1:0]),
    .out_valid (clamp_valid),
    .out_ready (clamp_ready),
    .out_freq  (clamp_freq)
  );

  // Stage 2: choose the prescaler, scale the divisor, flag overflow early.
  logic          div_valid [NSTEP+1];
  logic          div_ready [NSTEP+1];
  sfp_pkg::div_t div_data  [NSTEP+1];

  sfp_prescale u_prescale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (clamp_valid),
    .in_ready  (clamp_ready),
    .in_freq   (clamp_freq),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .out_data  (div_data[0])
  );

  // Stages 3..19: one quotient bit per stage, numerator bits fed from the
  // constant, most significant of the remaining low bits first.
  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    sfp_div_stage u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .num_bit   (sfp_pkg::NUMERATOR[NSTEP-1-k]),
      .in_valid  (div_valid[k]),
      .in_ready  (div_ready[k]),
      .in_data   (div_data[k]),
      .out_valid (div_valid[k+1]),
      .out_ready (div_ready[k+1]),
      .out_data  (div_data[k+1])
    );
  end

  // Stage 20: subtract one, saturate, and hold the result for the consumer.
  logic [sfp_pkg::PERIOD_W-1:0] period;
  sfp_pkg::clksel_t             code;

  sfp_sat u_sat (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (div_valid[NSTEP]),
    .in_ready   (div_ready[NSTEP]),
    .in_data    (div_data[NSTEP]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_period (period),
    .out_code   (code)
  );

  assign out_tdata = {4'd0, code, period};

endmodule

`default_nettype wire
